>>> hw/rtl/positional_pid_with_deadband_unit_macros.svh
// Assertion helpers for the PID unit.
`ifndef POSITIONAL_PID_WITH_DEADBAND_UNIT_MACROS_SVH
`define POSITIONAL_PID_WITH_DEADBAND_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define PPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ppd_pkg.sv
package ppd_pkg;

    localparam int DataW  = 16;
    localparam int GainW  = 16;
    localparam int LimW   = 15;
    localparam int ErrW   = DataW + 1;
    localparam int DiffW  = ErrW + 1;
    localparam int FracW  = 8;
    localparam int IsumW  = 24;
    localparam int PiW    = ErrW + GainW + 1;
    localparam int DW     = DiffW + GainW + 1;
    localparam int SumW   = DW + 1;
    localparam int IdxW   = 3;

    localparam logic [GainW-1:0] GainPRst = 16'd2560;
    localparam logic [GainW-1:0] GainIRst = 16'd0;
    localparam logic [GainW-1:0] GainDRst = 16'd2048;
    localparam logic [LimW-1:0]  IntLimRst = 15'd7000;
    localparam logic [LimW-1:0]  DrvLimRst = 15'd7000;
    localparam logic [DataW-1:0] DeadbandRst = 16'd8;

    typedef enum logic [IdxW-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_DRIVE_LIMIT    = 3'd4,
        REG_DEADBAND       = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [GainW-1:0] gain_p;
        logic [GainW-1:0] gain_i;
        logic [GainW-1:0] gain_d;
        logic [LimW-1:0]  integral_limit;
        logic [LimW-1:0]  drive_limit;
        logic [DataW-1:0] deadband;
    } t_cfg;

    typedef struct packed {
        logic signed [PiW-1:0] p_prod;
        logic signed [PiW-1:0] i_prod;
        logic signed [DW-1:0]  d_prod;
        logic                  dead;
    } t_prod;

endpackage

>>> hw/rtl/positional_pid_with_deadband_unit.sv
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_setpoint, i_measured
// output    o_out_valid / i_out_ready   o_drive, o_in_deadband
// config    i_cfg_wr_en                 i_cfg_index, i_cfg_wdata
//
// One word per cycle sustained while the output is not stalled; a result passes through
// the input register at accept, then the product register, then the result register.
// The error/products stage carries the previous error and the accumulate/clamp stage
// carries the integral sum, so consecutive words update the loop state in order.
// Reset is synchronous, active low: registers return to defaults, state clears.
// A stalled output backs up through the stages; input stalls only when all three are full.
`include "positional_pid_with_deadband_unit_macros.svh"

module positional_pid_with_deadband_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [ppd_pkg::IdxW-1:0]         i_cfg_index,
    input  logic [ppd_pkg::GainW-1:0]        i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [ppd_pkg::DataW-1:0] i_setpoint,
    input  logic signed [ppd_pkg::DataW-1:0] i_measured,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [ppd_pkg::DataW-1:0] o_drive,
    output logic                             o_in_deadband
);

    ppd_pkg::t_cfg  r_cfg;
    ppd_pkg::t_prod prod;
    logic           prod_valid;
    logic           prod_ready;
    logic signed [ppd_pkg::DataW:0] drive_x;
    logic signed [ppd_pkg::DataW:0] dlim_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= ppd_pkg::GainPRst;
            r_cfg.gain_i         <= ppd_pkg::GainIRst;
            r_cfg.gain_d         <= ppd_pkg::GainDRst;
            r_cfg.integral_limit <= ppd_pkg::IntLimRst;
            r_cfg.drive_limit    <= ppd_pkg::DrvLimRst;
            r_cfg.deadband       <= ppd_pkg::DeadbandRst;
        end else if (i_cfg_wr_en) begin
            case (ppd_pkg::t_reg_idx'(i_cfg_index))
                ppd_pkg::REG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_wdata;
                end
                ppd_pkg::REG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_wdata;
                end
                ppd_pkg::REG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_wdata;
                end
                ppd_pkg::REG_INTEGRAL_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_wdata[ppd_pkg::LimW-1:0];
                end
                ppd_pkg::REG_DRIVE_LIMIT: begin
                    r_cfg.drive_limit <= i_cfg_wdata[ppd_pkg::LimW-1:0];
                end
                ppd_pkg::REG_DEADBAND: begin
                    r_cfg.deadband <= i_cfg_wdata;
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    ppd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_setpoint (i_setpoint),
        .i_measured (i_measured),
        .o_valid    (prod_valid),
        .i_ready    (prod_ready),
        .o_prod     (prod)
    );

    ppd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_prod  (prod),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_drive (o_drive),
        .o_dead  (o_in_deadband)
    );

    assign drive_x = {o_drive[ppd_pkg::DataW-1], o_drive};
    assign dlim_x  = {2'b00, r_cfg.drive_limit};

    `PPD_ASSERT_NOW(a_dead_zero, i_clk, i_rst_n, o_out_valid && o_in_deadband,
                    o_drive == '0, "drive not zero inside deadband")
    `PPD_ASSERT_NOW(a_drive_lim, i_clk, i_rst_n, o_out_valid,
                    (drive_x <= dlim_x) && (drive_x >= -dlim_x), "drive beyond limit")
    `PPD_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_in_ready,
                    o_out_valid && !i_out_ready && prod_valid,
                    "input stalled without output backpressure")
    `PPD_ASSERT_NEXT(a_drain, i_clk, i_rst_n, !o_out_valid && !prod_valid,
                     o_in_ready, "input stalled after pipeline drained")

endmodule

>>> hw/rtl/ppd_front.sv
module ppd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppd_pkg::t_cfg                   i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [ppd_pkg::DataW-1:0] i_setpoint,
    input  logic signed [ppd_pkg::DataW-1:0] i_measured,
    output logic                            o_valid,
    input  logic                            i_ready,
    output ppd_pkg::t_prod                  o_prod
);

    logic                              r_in_valid;
    logic signed [ppd_pkg::DataW-1:0]  r_sp;
    logic signed [ppd_pkg::DataW-1:0]  r_ms;
    logic signed [ppd_pkg::ErrW-1:0]   r_prev_err;
    logic                              r_pr_valid;
    ppd_pkg::t_prod                    r_prod;

    logic signed [ppd_pkg::ErrW-1:0]   err;
    logic signed [ppd_pkg::DiffW-1:0]  diff;
    logic signed [ppd_pkg::ErrW-1:0]   gp_s;
    logic signed [ppd_pkg::ErrW-1:0]   gi_s;
    logic signed [ppd_pkg::ErrW-1:0]   gd_s;
    logic        [ppd_pkg::ErrW-1:0]   mag;
    logic                              adv;
    ppd_pkg::t_prod                    n_prod;

    assign adv     = r_in_valid && (!r_pr_valid || i_ready);
    assign o_ready = !r_in_valid || adv;
    assign o_valid = r_pr_valid;
    assign o_prod  = r_prod;

    always_comb begin
        err  = $signed({r_sp[ppd_pkg::DataW-1], r_sp}) - $signed({r_ms[ppd_pkg::DataW-1], r_ms});
        diff = $signed({err[ppd_pkg::ErrW-1], err})
             - $signed({r_prev_err[ppd_pkg::ErrW-1], r_prev_err});
        gp_s = $signed({1'b0, i_cfg.gain_p});
        gi_s = $signed({1'b0, i_cfg.gain_i});
        gd_s = $signed({1'b0, i_cfg.gain_d});
        mag  = err[ppd_pkg::ErrW-1] ? ppd_pkg::ErrW'(-err) : ppd_pkg::ErrW'(err);
        n_prod.p_prod = err * gp_s;
        n_prod.i_prod = err * gi_s;
        n_prod.d_prod = diff * gd_s;
        n_prod.dead   = mag < {1'b0, i_cfg.deadband};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pr_valid <= 1'b0;
            r_prev_err <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_pr_valid <= 1'b1;
                r_prev_err <= err;
            end else if (i_ready) begin
                r_pr_valid <= 1'b0;
            end
        end
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sp <= i_setpoint;
            r_ms <= i_measured;
        end
        if (adv) begin
            r_prod <= n_prod;
        end
    end

endmodule

>>> hw/rtl/ppd_back.sv
module ppd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ppd_pkg::t_cfg                    i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  ppd_pkg::t_prod                   i_prod,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [ppd_pkg::DataW-1:0] o_drive,
    output logic                             o_dead
);

    localparam int TermW = ppd_pkg::SumW - ppd_pkg::FracW + 1;

    logic signed [ppd_pkg::IsumW-1:0] r_isum;
    logic                             r_out_valid;
    logic signed [ppd_pkg::DataW-1:0] r_drive;
    logic                             r_dead;

    logic signed [ppd_pkg::SumW-1:0]  isum_new;
    logic signed [ppd_pkg::SumW-1:0]  ilim;
    logic signed [ppd_pkg::SumW-1:0]  integ_c;
    logic signed [ppd_pkg::IsumW-1:0] integ;
    logic signed [TermW-1:0]          dterm;
    logic signed [TermW-1:0]          pterm;
    logic signed [TermW-1:0]          iterm;
    logic signed [TermW-1:0]          total;
    logic signed [TermW-1:0]          dlim;
    logic signed [TermW-1:0]          drv_c;
    logic signed [ppd_pkg::DataW-1:0] n_drive;
    logic                             take;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_drive = r_drive;
    assign o_dead  = r_dead;

    always_comb begin
        isum_new = ppd_pkg::SumW'(r_isum) + ppd_pkg::SumW'(i_prod.i_prod);
        ilim     = $signed({{(ppd_pkg::SumW - ppd_pkg::LimW - ppd_pkg::FracW){1'b0}},
                            i_cfg.integral_limit, {ppd_pkg::FracW{1'b0}}});
        if (isum_new > ilim) begin
            integ_c = ilim;
        end else if (isum_new < -ilim) begin
            integ_c = -ilim;
        end else begin
            integ_c = isum_new;
        end
        integ = integ_c[ppd_pkg::IsumW-1:0];

        // drop the fraction bits: arithmetic shift rounds toward minus infinity
        dterm = TermW'($signed(i_prod.d_prod[ppd_pkg::DW-1:ppd_pkg::FracW]));
        pterm = TermW'($signed(i_prod.p_prod[ppd_pkg::PiW-1:ppd_pkg::FracW]));
        iterm = TermW'($signed(integ[ppd_pkg::IsumW-1:ppd_pkg::FracW]));
        total = dterm + pterm + iterm;

        dlim = $signed({{(TermW - ppd_pkg::LimW){1'b0}}, i_cfg.drive_limit});
        if (total > dlim) begin
            drv_c = dlim;
        end else if (total < -dlim) begin
            drv_c = -dlim;
        end else begin
            drv_c = total;
        end
        n_drive = i_prod.dead ? '0 : drv_c[ppd_pkg::DataW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_isum      <= '0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_isum      <= integ;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_drive <= n_drive;
            r_dead  <= i_prod.dead;
        end
    end

endmodule

>>> dv/positional_pid_with_deadband_unit_test.sv
module positional_pid_with_deadband_unit_test;
    import ppd_pkg::*;

    localparam int CycleLimit = 500000;
    localparam int DrainCycles = 8;
    localparam logic [IdxW-1:0] IdxSpareLo = 3'd6;
    localparam logic [IdxW-1:0] IdxSpareHi = 3'd7;

    typedef struct packed {
        logic signed [DataW-1:0] drive;
        logic                    dead;
    } pid_result_t;

    class pid_drive_tracker;
        logic [GainW-1:0] kp, ki, kd;
        logic [LimW-1:0]  integ_lim, drive_lim;
        logic [DataW-1:0] dband;
        longint           last_err, integ_acc;
        pid_result_t      pending_drives[$];
        int               drives_checked, drive_mismatches;

        function new();
            kp = GainPRst;
            ki = GainIRst;
            kd = GainDRst;
            integ_lim = IntLimRst;
            drive_lim = DrvLimRst;
            dband = DeadbandRst;
            last_err = 0;
            integ_acc = 0;
            drives_checked = 0;
            drive_mismatches = 0;
        endfunction

        function void write_reg(logic [IdxW-1:0] idx, logic [GainW-1:0] data);
            case (idx)
                REG_GAIN_P:         kp = data;
                REG_GAIN_I:         ki = data;
                REG_GAIN_D:         kd = data;
                REG_INTEGRAL_LIMIT: integ_lim = data[LimW-1:0];
                REG_DRIVE_LIMIT:    drive_lim = data[LimW-1:0];
                REG_DEADBAND:       dband = data;
                default: ;
            endcase
        endfunction

        // Every shift right by 8 is arithmetic on a signed 64-bit value, so it floors.
        function void predict_drive(logic signed [DataW-1:0] sp, logic signed [DataW-1:0] meas);
            longint err, d_term, p_term, i_bound, integ, total, mag;
            pid_result_t r;
            err = longint'(sp) - longint'(meas);
            d_term = ((err - last_err) * longint'(kd)) >>> FracW;
            p_term = (err * longint'(kp)) >>> FracW;
            i_bound = longint'(integ_lim) * 256;
            integ = integ_acc + err * longint'(ki);
            if (integ > i_bound) integ = i_bound;
            if (integ < -i_bound) integ = -i_bound;
            total = d_term + p_term + (integ >>> FracW);
            if (total > longint'(drive_lim)) total = longint'(drive_lim);
            if (total < -longint'(drive_lim)) total = -longint'(drive_lim);
            mag = (err < 0) ? -err : err;
            r.dead = (mag < longint'(dband));
            r.drive = r.dead ? '0 : total[DataW-1:0];
            // loop state advances inside the deadband as well
            integ_acc = integ;
            last_err = err;
            pending_drives.push_back(r);
        endfunction

        function void compare_drive(logic signed [DataW-1:0] drive, logic dead);
            pid_result_t exp_r;
            if (pending_drives.size() == 0) begin
                $error("result word with no input pending: drive %0d, in_deadband %0b",
                       drive, dead);
                drive_mismatches++;
                return;
            end
            exp_r = pending_drives.pop_front();
            drives_checked++;
            if (drive !== exp_r.drive) begin
                $error("drive: expected %0d, got %0d", exp_r.drive, drive);
                drive_mismatches++;
            end
            if (dead !== exp_r.dead) begin
                $error("in_deadband: expected %0b, got %0b", exp_r.dead, dead);
                drive_mismatches++;
            end
        endfunction

        function int pending();
            return pending_drives.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [IdxW-1:0]         i_cfg_index = '0;
    logic [GainW-1:0]        i_cfg_wdata = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [DataW-1:0] i_setpoint = '0;
    logic signed [DataW-1:0] i_measured = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [DataW-1:0] o_drive;
    logic                    o_in_deadband;

    pid_drive_tracker pid_sb = new();
    int  cycles = 0;
    int  stall_left = 0;
    int  settings_loaded = 0;
    bit  stall_on = 1'b0;
    bit  gaps_on = 1'b0;

    positional_pid_with_deadband_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_setpoint    (i_setpoint),
        .i_measured    (i_measured),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_drive       (o_drive),
        .o_in_deadband (o_in_deadband)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("positional_pid_with_deadband_unit test failed");
            $finish;
        end
    end

    // Sample both handshakes on the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                pid_sb.predict_drive(i_setpoint, i_measured);
            if (o_out_valid && i_out_ready)
                pid_sb.compare_drive(o_drive, o_in_deadband);
        end
    end

    always @(posedge i_clk) begin
        if (!stall_on) begin
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            stall_left <= $urandom_range(5, 30);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [GainW-1:0] pick_reg_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) return GainW'($urandom_range(0, 16'hFFFF));
        return GainW'($urandom_range(0, 1024));
    endfunction

    function automatic logic signed [DataW-1:0] sat16(int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[DataW-1:0];
    endfunction

    // Hold valid and payload until accepted; drop valid only when a gap follows.
    task automatic send_word(logic signed [DataW-1:0] sp, logic signed [DataW-1:0] meas);
        int gap;
        i_in_valid <= 1'b1;
        i_setpoint <= sp;
        i_measured <= meas;
        do @(posedge i_clk); while (!o_in_ready);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pid_sb.pending() != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IdxW-1:0] idx, logic [GainW-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        pid_sb.write_reg(idx, data);
    endtask

    // Spare indexes sit between real writes so a decode slip would corrupt a register.
    task automatic load_settings(logic [GainW-1:0] kp, logic [GainW-1:0] ki,
                                 logic [GainW-1:0] kd, logic [GainW-1:0] ilim,
                                 logic [GainW-1:0] dlim, logic [GainW-1:0] dband);
        drain();
        write_reg(REG_GAIN_P, kp);
        write_reg(IdxSpareLo, GainW'($urandom_range(0, 16'hFFFF)));
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(IdxSpareHi, GainW'($urandom_range(0, 16'hFFFF)));
        write_reg(REG_INTEGRAL_LIMIT, ilim);
        write_reg(REG_DRIVE_LIMIT, dlim);
        write_reg(REG_DEADBAND, dband);
        i_cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    initial begin : stimulus
        int track_sp, track_meas, e, sp, r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: deadband edges and full-scale error swings.
        gaps_on = 1'b1;
        stall_on <= 1'b1;
        send_word(0, 0);
        send_word(7, 0);
        send_word(8, 0);
        send_word(0, 7);
        send_word(0, 8);
        send_word(32767, -32768);
        send_word(-32768, 32767);
        send_word(-32768, -32768);
        send_word(-3, 200);

        // Maximum proportional gain, bit 15 of the limit writes dropped, no deadband.
        load_settings(16'hFFFF, 16'h0101, 16'd3, 16'hFFFF, 16'hFFFF, 16'd0);
        send_word(0, 1);
        send_word(1, 0);
        send_word(32767, -32768);
        send_word(-32768, 32767);
        send_word(0, 0);
        send_word(-32768, -32768);

        // Zero limits with the widest deadband.
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_word(100, -100);
        send_word(32767, -32768);
        send_word(-5, 5);

        track_sp = 1000;
        track_meas = -1000;
        for (int ph = 0; ph < 8; ph++) begin
            load_settings(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                          pick_reg_value(), pick_reg_value(), pick_reg_value());
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on <= ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 88; n++) begin
                r = $urandom_range(0, 9);
                if (r < 2) begin
                    send_word(DataW'($urandom_range(0, 16'hFFFF)),
                              DataW'($urandom_range(0, 16'hFFFF)));
                end else if (r < 8) begin
                    // closed-loop style trajectory: measured chases a setpoint
                    if ($urandom_range(0, 39) == 0)
                        track_sp = int'($urandom_range(0, 65535)) - 32768;
                    track_meas = track_meas + (track_sp - track_meas) / 8
                                 + int'($urandom_range(0, 40)) - 20;
                    track_meas = sat16(track_meas);
                    send_word(sat16(track_sp), sat16(track_meas));
                end else begin
                    // hover around the deadband edge
                    e = int'(pid_sb.dband) + int'($urandom_range(0, 2)) - 1;
                    if ($urandom_range(0, 1) != 0) e = -e;
                    sp = int'($urandom_range(0, 40000)) - 20000;
                    send_word(sat16(sp), sat16(sp - e));
                end
            end
        end

        drain();
        $display("%0d result words compared over %0d register settings",
                 pid_sb.drives_checked, settings_loaded + 1);
        $display("directed deadband, limit and full-scale words, then tracking and noise");
        if (pid_sb.drive_mismatches == 0 && pid_sb.pending() == 0)
            $display("positional_pid_with_deadband_unit test passed");
        else
            $display("positional_pid_with_deadband_unit test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_front.sv
hw/rtl/ppd_back.sv
hw/rtl/positional_pid_with_deadband_unit.sv
dv/positional_pid_with_deadband_unit_test.sv
